/* hw/rtl/fiw_pkg.sv */
package fiw_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int CFG_W      = 6;
  localparam int FREE_W     = 6;
  localparam int ENTRY_W    = 32;
  localparam int CMP_W      = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH        = 3'd0,
    OP_TAKE        = 3'd1,
    OP_RELEASE     = 3'd2,
    OP_DROP        = 3'd3,
    OP_CLR_HANDLED = 3'd4,
    OP_CLR_ALL     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOTFLIGHT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_WAIT = 2'd2
  } state_t;

  typedef struct packed {
    logic    push;
    logic    rd_en;
    logic    rd_take;
    logic    take;
    logic    pop;
    logic    clr_inflight;
    logic    load;
    logic    entry_valid;
    status_t status;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic none_to_take;
    logic no_inflight;
    logic fin_handled;
    logic fin_all;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/fifo_with_inflight_window_core.sv */
// push, unknown ops and ops that find nothing to do: result goes into the result register as the beat is taken
// take, release, drop: the entry ram read is registered first, then the result register is loaded
// clears: one result per removed entry, each through the entry ram read; the next read waits while out_tready is low
// a new beat is taken once the result of the previous one is leaving and all entry ram reads
// for it are done, so take, release, drop and clears hold off the next beat until then
// rst_n (synchronous, active low) empties the queue and sets max_entries to 32
module fifo_with_inflight_window_core
  import fiw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // payload[31:0]
  input  logic [2:0]       in_tuser,   // op[2:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,  // entry_data[31:0], free_slots[37:32], zero[39:38]
  output logic [2:0]       out_tuser,  // entry_valid[0], status[2:1]
  output logic             out_tlast
);

  cmd_t               cmd;
  stat_t              stat;
  logic [ENTRY_W-1:0] entry_data;
  logic               entry_valid;
  status_t            status;
  logic [FREE_W-1:0]  free_slots;

  fiw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .op        (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  fiw_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .payload     (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .entry_data  (entry_data),
    .entry_valid (entry_valid),
    .status      (status),
    .free_slots  (free_slots),
    .last        (out_tlast)
  );

  assign out_tdata = {2'b00, free_slots, entry_data};
  assign out_tuser = {status, entry_valid};

  a_accept_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!out_tvalid || out_tready))
    else $error("input beat taken while result register busy");

  a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[31:0] == 32'd0))
    else $error("entry_data not zero without entry");

  a_ok_carries_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[2:1] == ST_OK))
    else $error("entry reported with error status");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:1] != ST_OK)) |-> out_tlast)
    else $error("error result not marked last");

endmodule

/* hw/rtl/fiw_ram.sv */
module fiw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/fiw_ctrl.sv */
module fiw_ctrl
  import fiw_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [OP_W-1:0] op,
  input  stat_t           stat,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_PUSH;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.status = ST_OK;
    cmd.last   = 1'b1;
    in_tready = (state_r == S_IDLE) && stat.out_free;
    accept    = in_tvalid && in_tready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = op_t'(op);
          case (op_t'(op))
            OP_PUSH: begin
              cmd.load = 1'b1;
              if (stat.full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            OP_TAKE: begin
              if (stat.none_to_take) begin
                cmd.load   = 1'b1;
                cmd.status = ST_NONE;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_take = 1'b1;
                state_nxt   = S_READ;
              end
            end
            OP_RELEASE: begin
              if (stat.empty) begin
                cmd.load   = 1'b1;
                cmd.status = ST_NONE;
              end else if (stat.no_inflight) begin
                cmd.load   = 1'b1;
                cmd.status = ST_NOTFLIGHT;
              end else begin
                cmd.rd_en = 1'b1;
                state_nxt = S_READ;
              end
            end
            OP_DROP, OP_CLR_ALL: begin
              if (stat.empty) begin
                cmd.load   = 1'b1;
                cmd.status = ST_NONE;
              end else begin
                cmd.rd_en = 1'b1;
                state_nxt = S_READ;
              end
            end
            OP_CLR_HANDLED: begin
              if (stat.empty || stat.no_inflight) begin
                cmd.load   = 1'b1;
                cmd.status = ST_NONE;
              end else begin
                cmd.rd_en = 1'b1;
                state_nxt = S_READ;
              end
            end
            default: begin
              cmd.load   = 1'b1;
              cmd.status = ST_NONE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.load        = 1'b1;
        cmd.entry_valid = 1'b1;
        state_nxt       = S_IDLE;
        case (op_r)
          OP_TAKE: begin
            cmd.take = 1'b1;
          end
          OP_CLR_HANDLED: begin
            cmd.pop  = 1'b1;
            cmd.last = stat.fin_handled;
            if (!stat.fin_handled) begin
              state_nxt = S_WAIT;
            end
          end
          OP_CLR_ALL: begin
            cmd.pop          = 1'b1;
            cmd.last         = stat.fin_all;
            cmd.clr_inflight = stat.fin_all;
            if (!stat.fin_all) begin
              state_nxt = S_WAIT;
            end
          end
          default: begin
            cmd.pop = 1'b1;
          end
        endcase
      end
      S_WAIT: begin
        if (stat.out_free) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/fiw_datapath.sv */
module fiw_datapath
  import fiw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [ENTRY_W-1:0] payload,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ENTRY_W-1:0] entry_data,
  output logic              entry_valid,
  output status_t           status,
  output logic [FREE_W-1:0] free_slots,
  output logic              last
);

  logic [CFG_W-1:0]      max_entries_r;
  logic [IDX_W-1:0]      oldest_r, oldest_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      inflight_r, inflight_nxt;
  logic [CNT_W-1:0]      cap;
  logic [CNT_W-1:0]      free_nxt;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  out_valid_r;
  logic [ENTRY_W-1:0]    out_data_r;
  logic                  out_ev_r;
  status_t               out_st_r;
  logic [FREE_W-1:0]     out_free_r;
  logic                  out_last_r;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return IDX_W'(s);
  endfunction

  always_comb begin
    if (CMP_W'(max_entries_r) > CMP_W'(DEPTH)) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = CNT_W'(max_entries_r);
    end
  end

  assign waddr = wrap_add(oldest_r, count_r);
  assign raddr = cmd.rd_take ? wrap_add(oldest_r, inflight_r) : oldest_r;

  fiw_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (waddr),
    .wdata (payload[DATA_WIDTH-1:0]),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    oldest_nxt   = oldest_r;
    count_nxt    = count_r;
    inflight_nxt = inflight_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.take) begin
      inflight_nxt = inflight_r + CNT_W'(1);
    end
    if (cmd.pop) begin
      oldest_nxt = wrap_add(oldest_r, CNT_W'(1));
      count_nxt  = count_r - CNT_W'(1);
      if (inflight_r != '0) begin
        inflight_nxt = inflight_r - CNT_W'(1);
      end
    end
    if (cmd.clr_inflight) begin
      inflight_nxt = '0;
    end
    free_nxt = (cap > count_nxt) ? (cap - count_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= CFG_W'(32);
      oldest_r      <= '0;
      count_r       <= '0;
      inflight_r    <= '0;
    end else begin
      if (cfg_we) begin
        max_entries_r <= cfg_wdata;
      end
      oldest_r   <= oldest_nxt;
      count_r    <= count_nxt;
      inflight_r <= inflight_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= cmd.entry_valid ? ENTRY_W'(rdata) : '0;
      out_ev_r   <= cmd.entry_valid;
      out_st_r   <= cmd.status;
      out_free_r <= FREE_W'(free_nxt);
      out_last_r <= cmd.last;
    end
  end

  assign stat.empty        = (count_r == '0);
  assign stat.full         = (count_r >= cap);
  assign stat.none_to_take = (inflight_r >= count_r);
  assign stat.no_inflight  = (inflight_r == '0);
  assign stat.fin_all      = (count_r == CNT_W'(1));
  assign stat.fin_handled  = (count_r == CNT_W'(1)) || (inflight_r <= CNT_W'(1));
  assign stat.out_free     = !out_valid_r || out_tready;

  assign out_tvalid  = out_valid_r;
  assign entry_data  = out_data_r;
  assign entry_valid = out_ev_r;
  assign status      = out_st_r;
  assign free_slots  = out_free_r;
  assign last        = out_last_r;

endmodule

/* bench/fiw_checker.sv */
module fiw_checker
  import fiw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [31:0]      in_tdata,
  input  logic [2:0]       in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [39:0]      out_tdata,
  input  logic [2:0]       out_tuser,
  input  logic             out_tlast,
  output int               err_cnt,
  output int               pend_cnt,
  output int               beats_in,
  output int               beats_out
);

  typedef struct {
    logic [ENTRY_W-1:0] data;
    logic               valid;
    status_t            status;
    logic [FREE_W-1:0]  free;
    logic               last;
  } queue_result_t;

  queue_result_t         expected_results[$];
  logic [DATA_WIDTH-1:0] slots[DEPTH];
  logic [IDX_W-1:0]      head;
  logic [CNT_W-1:0]      held;
  logic [CNT_W-1:0]      in_flight;
  logic [CFG_W-1:0]      max_ent;

  function automatic int capacity();
    return (int'(max_ent) > DEPTH) ? DEPTH : int'(max_ent);
  endfunction

  task automatic note_result(input logic [ENTRY_W-1:0] data, input logic valid,
                             input status_t status, input logic last);
    queue_result_t r;
    r.data   = valid ? data : '0;
    r.valid  = valid;
    r.status = status;
    r.free   = (capacity() > int'(held)) ? FREE_W'(capacity() - int'(held)) : '0;
    r.last   = last;
    expected_results.push_back(r);
  endtask

  task automatic pop_oldest(output logic [ENTRY_W-1:0] data);
    data = ENTRY_W'(slots[head]);
    head = IDX_W'((int'(head) + 1) % DEPTH);
    held = held - CNT_W'(1);
    if (in_flight != 0) in_flight = in_flight - CNT_W'(1);
  endtask

  task automatic apply_queue_op(input logic [OP_W-1:0] op, input logic [31:0] payload);
    logic [ENTRY_W-1:0] d;
    case (op)
      OP_PUSH: begin
        if (int'(held) >= capacity()) begin
          note_result('0, 1'b0, ST_FULL, 1'b1);
        end else begin
          slots[(int'(head) + int'(held)) % DEPTH] = DATA_WIDTH'(payload);
          held = held + CNT_W'(1);
          note_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_TAKE: begin
        if (in_flight < held) begin
          d = ENTRY_W'(slots[(int'(head) + int'(in_flight)) % DEPTH]);
          in_flight = in_flight + CNT_W'(1);
          note_result(d, 1'b1, ST_OK, 1'b1);
        end else begin
          note_result('0, 1'b0, ST_NONE, 1'b1);
        end
      end
      OP_RELEASE: begin
        if (held == 0) begin
          note_result('0, 1'b0, ST_NONE, 1'b1);
        end else if (in_flight == 0) begin
          note_result('0, 1'b0, ST_NOTFLIGHT, 1'b1);
        end else begin
          pop_oldest(d);
          note_result(d, 1'b1, ST_OK, 1'b1);
        end
      end
      OP_DROP: begin
        if (held == 0) begin
          note_result('0, 1'b0, ST_NONE, 1'b1);
        end else begin
          pop_oldest(d);
          note_result(d, 1'b1, ST_OK, 1'b1);
        end
      end
      OP_CLR_HANDLED: begin
        if (in_flight == 0 || held == 0) begin
          note_result('0, 1'b0, ST_NONE, 1'b1);
        end else begin
          while (in_flight != 0 && held != 0) begin
            pop_oldest(d);
            note_result(d, 1'b1, ST_OK, in_flight == 0 || held == 0);
          end
        end
      end
      OP_CLR_ALL: begin
        if (held == 0) begin
          note_result('0, 1'b0, ST_NONE, 1'b1);
        end else begin
          while (held != 0) begin
            pop_oldest(d);
            note_result(d, 1'b1, ST_OK, held == 0);
          end
          in_flight = '0;
        end
      end
      default: begin
        note_result('0, 1'b0, ST_NONE, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      head      = '0;
      held      = '0;
      in_flight = '0;
      max_ent   = CFG_W'(32);
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        beats_out++;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, tdata %h tuser %h tlast %b",
                   $time, out_tdata, out_tuser, out_tlast);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("entry_data", want.data, out_tdata[31:0]);
          check_field("free_slots", 32'(want.free), 32'(out_tdata[37:32]));
          check_field("entry_valid", 32'(want.valid), 32'(out_tuser[0]));
          check_field("status", 32'(want.status), 32'(out_tuser[2:1]));
          check_field("last", 32'(want.last), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        beats_in++;
        apply_queue_op(in_tuser, in_tdata);
      end
      if (cfg_we) max_ent = cfg_wdata;
    end
    pend_cnt = expected_results.size();
  end

endmodule

/* bench/tb_top.sv */
module tb_top;
  import fiw_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
  localparam int              STALL_LIMIT = 3000;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_we     = 1'b0;
  logic [CFG_W-1:0] cfg_wdata  = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata   = '0;
  logic [2:0]       in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [39:0]      out_tdata;
  logic [2:0]       out_tuser;
  logic             out_tlast;

  int   err_cnt;
  int   pend_cnt;
  int   beats_in;
  int   beats_out;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;
  int   quiet_cycles  = 0;
  logic in_acc        = 1'b0;

  fifo_with_inflight_window_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  fiw_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .err_cnt    (err_cnt),
    .pend_cnt   (pend_cnt),
    .beats_in   (beats_in),
    .beats_out  (beats_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pend_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [31:0] payload);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= payload;
    @(negedge clk);
    while (!in_acc) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pend_cnt != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cap(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_payload();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int push_pct);
    int r;
    if ($urandom_range(99) < push_pct) return OP_PUSH;
    r = $urandom_range(99);
    if (r < 40) return OP_TAKE;
    if (r < 70) return OP_RELEASE;
    if (r < 82) return OP_DROP;
    if (r < 90) return OP_CLR_HANDLED;
    if (r < 96) return OP_CLR_ALL;
    return (r < 98) ? OP_RSVD_6 : OP_RSVD_7;
  endfunction

  task automatic run_ops(input int count, input int push_pct);
    for (int i = 0; i < count; i++) begin
      send_beat(pick_op(push_pct), rand_payload());
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue, reserved ops
    send_beat(OP_RELEASE, '0);
    send_beat(OP_DROP, '0);
    send_beat(OP_TAKE, '0);
    send_beat(OP_CLR_HANDLED, '0);
    send_beat(OP_CLR_ALL, '0);
    send_beat(OP_RSVD_6, '1);
    send_beat(OP_RSVD_7, '1);
    // window walk
    send_beat(OP_PUSH, 32'h0000_0000);
    send_beat(OP_PUSH, 32'hffff_ffff);
    send_beat(OP_PUSH, 32'ha5a5_a5a5);
    send_beat(OP_PUSH, 32'h5a5a_5a5a);
    send_beat(OP_RELEASE, '0);
    send_beat(OP_CLR_HANDLED, '0);
    send_beat(OP_TAKE, '0);
    send_beat(OP_TAKE, '0);
    send_beat(OP_RELEASE, '0);
    send_beat(OP_DROP, '0);
    send_beat(OP_TAKE, '0);
    send_beat(OP_TAKE, '0);
    send_beat(OP_TAKE, '0);
    send_beat(OP_CLR_HANDLED, '1);
    send_beat(OP_PUSH, 32'h1234_5678);
    send_beat(OP_PUSH, 32'h8765_4321);
    send_beat(OP_TAKE, '0);
    send_beat(OP_CLR_ALL, '0);

    write_cap(CFG_W'(32));
    run_ops(45, 85);
    run_ops(25, 40);

    in_idle_pct = 68;
    write_cap(CFG_W'(1));
    run_ops(50, 50);

    in_idle_pct   = 0;
    out_stall_pct = 68;
    write_cap(CFG_W'(63));
    run_ops(70, 55);

    // shrink capacity below the fill level
    in_idle_pct   = 12;
    out_stall_pct = 12;
    write_cap(CFG_W'(32));
    for (int i = 0; i < 10; i++) send_beat(OP_PUSH, rand_payload());
    write_cap(CFG_W'(3));
    run_ops(60, 45);

    in_idle_pct   = 0;
    out_stall_pct = 0;
    write_cap(CFG_W'(0));
    run_ops(20, 50);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("covered %0d input beats and %0d result beats", beats_in, beats_out);
    $display("capacities 32, 1, 63, 3 and 0 with idle sender, stalled receiver and both");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
